// File: hw/rtl/boxds_pkg.sv
// Shared constants, types and the reciprocal table of the box-average downscaler.
`timescale 1ns / 1ps
`default_nettype none
package boxds_pkg;

	localparam int MAX_WIDTH_DEF  = 4096;
	localparam int MAX_FACTOR_DEF = 8;

	localparam int CH           = 3;
	localparam int PIX_W        = 8;
	localparam int FACTOR_W     = 4;
	localparam int DIM_W        = 13;
	localparam int HEIGHT_LIMIT = 4096;

	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	localparam logic [FACTOR_W-1:0] FACTOR_RESET    = 4'd2;
	localparam logic [DIM_W-1:0]    IN_WIDTH_RESET  = 13'd640;
	localparam logic [DIM_W-1:0]    IN_HEIGHT_RESET = 13'd480;

	typedef enum logic [1:0] {
		REG_FACTOR    = 2'd0,
		REG_IN_WIDTH  = 2'd1,
		REG_IN_HEIGHT = 2'd2
	} reg_idx_t;

	// floor(n * RECIP[f] >> RECIP_K) == floor(n / f^2) for every n below 256 * f^2
	localparam int RECIP_K = 24;
	localparam int RECIP_W = 25;

	localparam logic [RECIP_W-1:0] RECIP_TABLE [16] = '{
		25'((2**24 + 0) / 1),
		25'((2**24 + 0) / 1),
		25'((2**24 + 3) / 4),
		25'((2**24 + 8) / 9),
		25'((2**24 + 15) / 16),
		25'((2**24 + 24) / 25),
		25'((2**24 + 35) / 36),
		25'((2**24 + 48) / 49),
		25'((2**24 + 63) / 64),
		25'((2**24 + 80) / 81),
		25'((2**24 + 99) / 100),
		25'((2**24 + 120) / 121),
		25'((2**24 + 143) / 144),
		25'((2**24 + 168) / 169),
		25'((2**24 + 195) / 196),
		25'((2**24 + 224) / 225)
	};

	// effective (clamped) configuration
	typedef struct packed {
		logic [FACTOR_W-1:0] factor;
		logic [DIM_W-1:0]    width;
		logic [DIM_W-1:0]    height;
	} cfg_t;

	// control part of a finished block row heading for the column memory
	typedef struct packed {
		logic valid;
		logic seed_zero;
		logic last_row;
		logic frame_end;
	} req_ctl_t;

endpackage
`default_nettype wire

// File: hw/rtl/box_average_downscale.sv
// Top level of the box-average image downscaler.
// Downscales a raster-order RGB pixel stream by an integer factor on each axis: every
// factor-by-factor block is summed per channel and its truncated average comes out as
// one word, flagged with frame_end on the last block of the image. Partial rows and
// columns past the last whole block are consumed and ignored. One input word is taken
// per clock; the pipeline (partial-sum logic, column memory read-modify-write, reciprocal
// multiply, output register) stalls only while the output word is held back. A result is
// registered in the column memory, multiply and output stages. The column memory has
// MAX_WIDTH entries of three channel sums, one read and one write port; the first row of
// each block band seeds it with zero, so it needs no clearing after reset. A register
// write restarts the frame and must be made while no word is in flight.
`timescale 1ns / 1ps
`default_nettype none
module box_average_downscale
	import boxds_pkg::*;
#(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_FACTOR = MAX_FACTOR_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [PIX_W-1:0]   in_red,
	input  wire logic [PIX_W-1:0]   in_green,
	input  wire logic [PIX_W-1:0]   in_blue,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic      [PIX_W-1:0]   out_red,
	output logic      [PIX_W-1:0]   out_green,
	output logic      [PIX_W-1:0]   out_blue,
	output logic                    frame_end
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int PW = $clog2(MAX_FACTOR * 255 + 1);
	localparam int SW = $clog2(MAX_FACTOR * MAX_FACTOR * 255 + 1);

	cfg_t                     cfg;
	logic                     restart;
	logic                     accept;
	logic [CH-1:0][PIX_W-1:0] pix;
	req_ctl_t                 req;
	logic [AW-1:0]            req_addr;
	logic [CH-1:0][PW-1:0]    req_part;
	logic                     s1_ready;
	logic                     div_valid, div_ready, div_frame_end;
	logic [CH-1:0][SW-1:0]    div_total;
	logic [CH-1:0][PIX_W-1:0] out_pix;

	assign pix[0]   = in_red;
	assign pix[1]   = in_green;
	assign pix[2]   = in_blue;
	assign in_ready = s1_ready;
	assign accept   = in_valid && in_ready;

	boxds_regs #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_FACTOR (MAX_FACTOR)
	) u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg),
		.restart (restart)
	);

	boxds_ctrl #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_FACTOR (MAX_FACTOR)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.restart  (restart),
		.accept   (accept),
		.pix      (pix),
		.req      (req),
		.req_addr (req_addr),
		.req_part (req_part)
	);

	boxds_colmem #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_FACTOR (MAX_FACTOR)
	) u_colmem (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req),
		.req_addr      (req_addr),
		.req_part      (req_part),
		.s1_ready      (s1_ready),
		.div_valid     (div_valid),
		.div_ready     (div_ready),
		.div_total     (div_total),
		.div_frame_end (div_frame_end)
	);

	boxds_div #(
		.MAX_FACTOR (MAX_FACTOR)
	) u_div (
		.clk           (clk),
		.arst_n        (arst_n),
		.factor        (cfg.factor),
		.in_valid      (div_valid),
		.in_ready      (div_ready),
		.in_total      (div_total),
		.in_frame_end  (div_frame_end),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_pix       (out_pix),
		.out_frame_end (frame_end)
	);

	assign out_red   = out_pix[0];
	assign out_green = out_pix[1];
	assign out_blue  = out_pix[2];

endmodule
`default_nettype wire

// File: hw/rtl/boxds_regs.sv
// Configuration register file with APB-style access and clamping of the settings.
`timescale 1ns / 1ps
`default_nettype none
module boxds_regs
	import boxds_pkg::*;
#(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_FACTOR = MAX_FACTOR_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready,
	output cfg_t                    cfg,
	output logic                    restart
);

	localparam logic [FACTOR_W:0] MAXF = (FACTOR_W + 1)'(MAX_FACTOR);
	localparam logic [DIM_W+1:0]  MAXW = (DIM_W + 2)'(MAX_WIDTH);
	localparam logic [DIM_W:0]    MAXH = (DIM_W + 1)'(HEIGHT_LIMIT);

	logic [FACTOR_W-1:0] factor_q;
	logic [DIM_W-1:0]    in_width_q;
	logic [DIM_W-1:0]    in_height_q;
	logic                wr_c;
	logic [1:0]          idx_c;

	assign pready = 1'b1;
	assign wr_c   = psel && penable && pwrite;
	assign idx_c  = paddr[PADDR_W-1:2];

	always_comb begin
		restart = 1'b0;
		prdata  = '0;
		case (idx_c)
			REG_FACTOR: begin
				restart = wr_c;
				prdata  = PDATA_W'(factor_q);
			end
			REG_IN_WIDTH: begin
				restart = wr_c;
				prdata  = PDATA_W'(in_width_q);
			end
			REG_IN_HEIGHT: begin
				restart = wr_c;
				prdata  = PDATA_W'(in_height_q);
			end
			default: begin
				restart = 1'b0;
				prdata  = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			factor_q    <= FACTOR_RESET;
			in_width_q  <= IN_WIDTH_RESET;
			in_height_q <= IN_HEIGHT_RESET;
		end else if (wr_c) begin
			case (idx_c)
				REG_FACTOR:    factor_q    <= pwdata[FACTOR_W-1:0];
				REG_IN_WIDTH:  in_width_q  <= pwdata[DIM_W-1:0];
				REG_IN_HEIGHT: in_height_q <= pwdata[DIM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// zero takes effect as one, anything past the limit saturates
	always_comb begin
		if (factor_q == '0) begin
			cfg.factor = FACTOR_W'(1);
		end else if ({1'b0, factor_q} > MAXF) begin
			cfg.factor = FACTOR_W'(MAX_FACTOR);
		end else begin
			cfg.factor = factor_q;
		end
		if (in_width_q == '0) begin
			cfg.width = DIM_W'(1);
		end else if ((DIM_W + 2)'(in_width_q) > MAXW) begin
			cfg.width = DIM_W'(MAX_WIDTH);
		end else begin
			cfg.width = in_width_q;
		end
		if (in_height_q == '0) begin
			cfg.height = DIM_W'(1);
		end else if ({1'b0, in_height_q} > MAXH) begin
			cfg.height = DIM_W'(HEIGHT_LIMIT);
		end else begin
			cfg.height = in_height_q;
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/boxds_ctrl.sv
// Raster position tracking and per-row partial block sums.
`timescale 1ns / 1ps
`default_nettype none
module boxds_ctrl
	import boxds_pkg::*;
#(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_FACTOR = MAX_FACTOR_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire cfg_t                          cfg,
	input  wire logic                          restart,
	input  wire logic                          accept,
	input  wire logic [CH-1:0][PIX_W-1:0]      pix,
	output req_ctl_t                           req,
	output logic      [$clog2(MAX_WIDTH)-1:0]  req_addr,
	output logic      [CH-1:0][$clog2(MAX_FACTOR*255+1)-1:0] req_part
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int PW = $clog2(MAX_FACTOR * 255 + 1);

	logic [DIM_W-1:0]    col_q, row_q, cbase_q, rbase_q;
	logic [FACTOR_W-1:0] subc_q, subr_q;
	logic [AW-1:0]       blk_q;
	logic [CH-1:0][PW-1:0] part_q;

	logic [DIM_W:0]      f_ext_c, w_ext_c, h_ext_c;
	logic [DIM_W:0]      col_end_c, row_end_c;
	logic                col_used_c, row_used_c, in_used_c;
	logic                col_last_blk_c, row_last_blk_c;
	logic [FACTOR_W-1:0] fm1_c;
	logic                complete_c, last_row_c;
	logic                row_done_c, frame_done_c;
	logic                subc_wrap_c, subr_wrap_c;
	logic [CH-1:0][PW-1:0] sum_c;

	assign f_ext_c = (DIM_W + 1)'(cfg.factor);
	assign w_ext_c = {1'b0, cfg.width};
	assign h_ext_c = {1'b0, cfg.height};

	// a block counts only if it fits wholly inside the image
	assign col_end_c      = {1'b0, cbase_q} + f_ext_c;
	assign row_end_c      = {1'b0, rbase_q} + f_ext_c;
	assign col_used_c     = col_end_c <= w_ext_c;
	assign row_used_c     = row_end_c <= h_ext_c;
	assign in_used_c      = col_used_c && row_used_c;
	assign col_last_blk_c = (col_end_c + f_ext_c) > w_ext_c;
	assign row_last_blk_c = (row_end_c + f_ext_c) > h_ext_c;

	assign fm1_c      = cfg.factor - FACTOR_W'(1);
	assign complete_c = subc_q == fm1_c;
	assign last_row_c = subr_q == fm1_c;

	assign row_done_c   = ({1'b0, col_q} + (DIM_W + 1)'(1)) >= w_ext_c;
	assign frame_done_c = ({1'b0, row_q} + (DIM_W + 1)'(1)) >= h_ext_c;
	assign subc_wrap_c  = ({1'b0, subc_q} + (FACTOR_W + 1)'(1)) >= {1'b0, cfg.factor};
	assign subr_wrap_c  = ({1'b0, subr_q} + (FACTOR_W + 1)'(1)) >= {1'b0, cfg.factor};

	always_comb begin
		for (int c = 0; c < CH; c++) begin
			sum_c[c] = part_q[c] + PW'(pix[c]);
		end
	end

	assign req.valid     = accept && in_used_c && complete_c;
	assign req.seed_zero = subr_q == '0;
	assign req.last_row  = last_row_c;
	assign req.frame_end = col_last_blk_c && row_last_blk_c;
	assign req_addr      = blk_q;
	assign req_part      = sum_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			cbase_q <= '0;
			rbase_q <= '0;
			subc_q  <= '0;
			subr_q  <= '0;
			blk_q   <= '0;
			part_q  <= '0;
		end else if (restart) begin
			col_q   <= '0;
			row_q   <= '0;
			cbase_q <= '0;
			rbase_q <= '0;
			subc_q  <= '0;
			subr_q  <= '0;
			blk_q   <= '0;
			part_q  <= '0;
		end else if (accept) begin
			if (row_done_c) begin
				col_q   <= '0;
				cbase_q <= '0;
				subc_q  <= '0;
				blk_q   <= '0;
				part_q  <= '0;
				if (frame_done_c) begin
					row_q   <= '0;
					rbase_q <= '0;
					subr_q  <= '0;
				end else begin
					row_q <= row_q + DIM_W'(1);
					if (subr_wrap_c) begin
						subr_q  <= '0;
						rbase_q <= rbase_q + DIM_W'(cfg.factor);
					end else begin
						subr_q <= subr_q + FACTOR_W'(1);
					end
				end
			end else begin
				col_q <= col_q + DIM_W'(1);
				if (subc_wrap_c) begin
					subc_q  <= '0;
					cbase_q <= cbase_q + DIM_W'(cfg.factor);
					blk_q   <= blk_q + AW'(1);
				end else begin
					subc_q <= subc_q + FACTOR_W'(1);
				end
				// drop the row sum once its block row is handed on
				if (in_used_c) begin
					part_q <= complete_c ? '0 : sum_c;
				end
			end
		end
	end

	a_subc_in_block: assert property (@(posedge clk) disable iff (!arst_n)
		subc_q < cfg.factor)
		else $error("sub-column outside block");

	a_col_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		col_q < cfg.width && cbase_q <= col_q)
		else $error("column position outside row");

endmodule
`default_nettype wire

// File: hw/rtl/boxds_colmem.sv
// Column sum memory with read-modify-write of partial block sums.
`timescale 1ns / 1ps
`default_nettype none
module boxds_colmem
	import boxds_pkg::*;
#(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_FACTOR = MAX_FACTOR_DEF
) (
	input  wire logic                                        clk,
	input  wire logic                                        arst_n,
	input  wire req_ctl_t                                    req,
	input  wire logic [$clog2(MAX_WIDTH)-1:0]                req_addr,
	input  wire logic [CH-1:0][$clog2(MAX_FACTOR*255+1)-1:0] req_part,
	output logic                                             s1_ready,
	output logic                                             div_valid,
	input  wire logic                                        div_ready,
	output logic [CH-1:0][$clog2(MAX_FACTOR*MAX_FACTOR*255+1)-1:0] div_total,
	output logic                                             div_frame_end
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int PW = $clog2(MAX_FACTOR * 255 + 1);
	localparam int SW = $clog2(MAX_FACTOR * MAX_FACTOR * 255 + 1);

	logic [CH*SW-1:0] mem [MAX_WIDTH];
	logic [CH*SW-1:0] rd_q;

	logic                  valid_s1;
	logic                  seed_zero_s1, last_s1, frame_end_s1;
	logic [AW-1:0]         addr_s1;
	logic [CH-1:0][PW-1:0] part_s1;

	logic                  rd_en_c, wr_en_c;
	logic [CH-1:0][SW-1:0] total_c;

	// the first row of a band seeds with zero, so it needs no read
	assign rd_en_c  = req.valid && !req.seed_zero;
	assign wr_en_c  = valid_s1 && !last_s1;
	assign s1_ready = !valid_s1 || !last_s1 || div_ready;

	always_ff @(posedge clk) begin
		if (wr_en_c) begin
			mem[addr_s1] <= total_c;
		end
		if (rd_en_c) begin
			rd_q <= mem[req_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_ready && req.valid) begin
			seed_zero_s1 <= req.seed_zero;
			last_s1      <= req.last_row;
			frame_end_s1 <= req.frame_end;
			addr_s1      <= req_addr;
			part_s1      <= req_part;
		end
	end

	always_comb begin
		for (int c = 0; c < CH; c++) begin
			total_c[c] = (seed_zero_s1 ? SW'(0) : rd_q[c*SW +: SW]) + SW'(part_s1[c]);
		end
	end

	assign div_valid     = valid_s1 && last_s1;
	assign div_total     = total_c;
	assign div_frame_end = frame_end_s1;

	// a band's next access to a column comes at least two words later
	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd_en_c && wr_en_c && req_addr == addr_s1))
		else $error("column memory read and write collide");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && last_s1 && !div_ready |=>
			valid_s1 && $stable(part_s1) && (seed_zero_s1 || $stable(rd_q)))
		else $error("stalled block sum lost");

endmodule
`default_nettype wire

// File: hw/rtl/boxds_div.sv
// Division by factor squared through a reciprocal multiply, and the output register.
`timescale 1ns / 1ps
`default_nettype none
module boxds_div
	import boxds_pkg::*;
#(
	parameter int MAX_FACTOR = MAX_FACTOR_DEF
) (
	input  wire logic                                               clk,
	input  wire logic                                               arst_n,
	input  wire logic [FACTOR_W-1:0]                                factor,
	input  wire logic                                               in_valid,
	output logic                                                    in_ready,
	input  wire logic [CH-1:0][$clog2(MAX_FACTOR*MAX_FACTOR*255+1)-1:0] in_total,
	input  wire logic                                               in_frame_end,
	output logic                                                    out_valid,
	input  wire logic                                               out_ready,
	output logic [CH-1:0][PIX_W-1:0]                                out_pix,
	output logic                                                    out_frame_end
);

	localparam int SW = $clog2(MAX_FACTOR * MAX_FACTOR * 255 + 1);
	localparam int MW = SW + RECIP_W;

	logic [RECIP_W-1:0]    recip_q;
	logic                  valid_s2, frame_end_s2;
	logic [CH-1:0][MW-1:0] prod_s2;
	logic                  out_valid_q, out_frame_end_q;
	logic [CH-1:0][PIX_W-1:0] out_pix_q;
	logic                  out_take_c;

	assign out_take_c = !out_valid_q || out_ready;
	assign in_ready   = !valid_s2 || out_take_c;

	// settings must change only while idle (unenforced): the reciprocal lag is harmless
	always_ff @(posedge clk) begin
		recip_q <= RECIP_TABLE[factor];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s2 <= in_valid;
			end
			if (out_take_c) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			for (int c = 0; c < CH; c++) begin
				prod_s2[c] <= MW'(in_total[c]) * MW'(recip_q);
			end
			frame_end_s2 <= in_frame_end;
		end
		if (out_take_c && valid_s2) begin
			for (int c = 0; c < CH; c++) begin
				out_pix_q[c] <= prod_s2[c][RECIP_K +: PIX_W];
			end
			out_frame_end_q <= frame_end_s2;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_pix       = out_pix_q;
	assign out_frame_end = out_frame_end_q;

	a_s2_fill: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> valid_s2)
		else $error("accepted block average not staged");

endmodule
`default_nettype wire

// File: sim/box_average_downscale_tb.sv
// Self-checking testbench of the box-average downscaler: predicts every averaged word and checks it.
`timescale 1ns / 1ps
module box_average_downscale_tb;
	import boxds_pkg::*;

	typedef enum int unsigned {
		PACE_FULL,
		PACE_LIGHT,
		PACE_HEAVY
	} pace_t;

	typedef struct {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
		logic             frame_end;
	} box_word_t;

	localparam int unsigned REG_UNUSED    = 3;
	localparam int unsigned REG_COUNT     = 3;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned QUIET_LIMIT   = 2000;
	localparam int unsigned BIG_ITEMS     = 100;
	localparam int unsigned RANDOM_ITEMS  = 650;
	localparam int unsigned RANDOM_WORDS  = 48;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               psel      = 1'b0;
	logic               penable   = 1'b0;
	logic               pwrite    = 1'b0;
	logic [PADDR_W-1:0] paddr     = '0;
	logic [PDATA_W-1:0] pwdata    = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               in_valid  = 1'b0;
	logic               in_ready;
	logic [PIX_W-1:0]   in_red    = '0;
	logic [PIX_W-1:0]   in_green  = '0;
	logic [PIX_W-1:0]   in_blue   = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [PIX_W-1:0]   out_red;
	logic [PIX_W-1:0]   out_green;
	logic [PIX_W-1:0]   out_blue;
	logic               frame_end;

	// model of the block
	logic [FACTOR_W-1:0] cfg_factor = FACTOR_RESET;
	logic [DIM_W-1:0]    cfg_width  = IN_WIDTH_RESET;
	logic [DIM_W-1:0]    cfg_height = IN_HEIGHT_RESET;
	int unsigned         band_sums [MAX_WIDTH_DEF][CH];
	int unsigned         line_sum [CH];
	int unsigned         col_pos, row_pos, sub_col, sub_row;

	box_word_t   expected_boxes [$];
	box_word_t   oldest;
	int unsigned boxes_predicted = 0;
	int unsigned mismatches      = 0;
	int unsigned quiet_cycles    = 0;
	pace_t       src_pace        = PACE_FULL;
	pace_t       sink_pace       = PACE_FULL;

	box_average_downscale u_top (.*);

	always #2 clk = ~clk;

	task automatic report_mismatch(input string what, input int unsigned got, input int unsigned want);
		mismatches++;
		$display("%0t ns mismatch: %s got %0d want %0d", $time, what, got, want);
	endtask

	function automatic int unsigned draw_gap(input pace_t pace);
		case (pace)
			PACE_FULL: begin
				return 0;
			end
			PACE_LIGHT: begin
				return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
			end
			default: begin
				return $urandom_range(0, 18);
			end
		endcase
	endfunction

	function automatic int unsigned eff_factor();
		if (cfg_factor == 0) return 1;
		if (cfg_factor > MAX_FACTOR_DEF) return MAX_FACTOR_DEF;
		return cfg_factor;
	endfunction

	function automatic int unsigned eff_width();
		if (cfg_width == 0) return 1;
		if (cfg_width > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
		return cfg_width;
	endfunction

	function automatic int unsigned eff_height();
		if (cfg_height == 0) return 1;
		if (cfg_height > HEIGHT_LIMIT) return HEIGHT_LIMIT;
		return cfg_height;
	endfunction

	function automatic logic [PDATA_W-1:0] reg_value(input int unsigned idx);
		if (idx == REG_FACTOR) return PDATA_W'(cfg_factor);
		if (idx == REG_IN_WIDTH) return PDATA_W'(cfg_width);
		return PDATA_W'(cfg_height);
	endfunction

	function automatic logic [PIX_W-1:0] pick_channel(input bit saturate);
		if (saturate || $urandom_range(0, 7) == 0) return '1;
		if ($urandom_range(0, 7) == 0) return '0;
		return PIX_W'($urandom);
	endfunction

	// Accumulate one accepted pixel and queue the averaged word it completes, if any.
	task automatic predict_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
			input logic [PIX_W-1:0] b);
		int unsigned f, w, h, used_w, used_h, blk, c;
		int unsigned px [CH];
		int unsigned total [CH];
		box_word_t   word;
		f = eff_factor();
		w = eff_width();
		h = eff_height();
		used_w = (w / f) * f;
		used_h = (h / f) * f;
		px[0] = r;
		px[1] = g;
		px[2] = b;
		if (col_pos < used_w && row_pos < used_h) begin
			for (c = 0; c < CH; c++) line_sum[c] += px[c];
			if (sub_col == f - 1) begin
				blk = col_pos / f;
				for (c = 0; c < CH; c++) begin
					total[c] = ((sub_row == 0) ? 0 : band_sums[blk][c]) + line_sum[c];
					line_sum[c] = 0;
				end
				if (sub_row == f - 1) begin
					word.red       = PIX_W'(total[0] / (f * f));
					word.green     = PIX_W'(total[1] / (f * f));
					word.blue      = PIX_W'(total[2] / (f * f));
					word.frame_end = (col_pos == used_w - 1) && (row_pos == used_h - 1);
					expected_boxes.push_back(word);
					boxes_predicted++;
				end else begin
					for (c = 0; c < CH; c++) band_sums[blk][c] = total[c];
				end
			end
		end
		// advance raster position, wrapping at the end of the image
		if (col_pos >= w - 1) begin
			col_pos = 0;
			sub_col = 0;
			for (c = 0; c < CH; c++) line_sum[c] = 0;
			if (row_pos >= h - 1) begin
				row_pos = 0;
				sub_row = 0;
			end else begin
				row_pos++;
				sub_row = (sub_row + 1 >= f) ? 0 : sub_row + 1;
			end
		end else begin
			col_pos++;
			sub_col = (sub_col + 1 >= f) ? 0 : sub_col + 1;
		end
	endtask

	task automatic restart_frame();
		int unsigned c;
		for (c = 0; c < CH; c++) line_sum[c] = 0;
		col_pos = 0;
		row_pos = 0;
		sub_col = 0;
		sub_row = 0;
	endtask

	task automatic apb_access(input logic write, input int unsigned idx,
			input logic [PDATA_W-1:0] wdata, output logic [PDATA_W-1:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= write;
		paddr   <= PADDR_W'(idx * 4);
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic reg_write(input int unsigned idx, input logic [PDATA_W-1:0] value);
		logic [PDATA_W-1:0] unused;
		apb_access(1'b1, idx, value, unused);
		if (idx == REG_FACTOR) begin
			cfg_factor = value[FACTOR_W-1:0];
			restart_frame();
		end else if (idx == REG_IN_WIDTH) begin
			cfg_width = value[DIM_W-1:0];
			restart_frame();
		end else if (idx == REG_IN_HEIGHT) begin
			cfg_height = value[DIM_W-1:0];
			restart_frame();
		end
	endtask

	task automatic write_image_cfg(input logic [PDATA_W-1:0] factor,
			input logic [PDATA_W-1:0] width, input logic [PDATA_W-1:0] height);
		reg_write(REG_FACTOR, factor);
		reg_write(REG_IN_WIDTH, width);
		reg_write(REG_IN_HEIGHT, height);
	endtask

	task automatic check_registers();
		logic [PDATA_W-1:0] rd;
		int unsigned        idx;
		for (idx = 0; idx < REG_COUNT; idx++) begin
			apb_access(1'b0, idx, '0, rd);
			if (rd !== reg_value(idx)) report_mismatch("register readback", rd, reg_value(idx));
		end
	endtask

	task automatic send_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
			input logic [PIX_W-1:0] b);
		int unsigned hold;
		hold = draw_gap(src_pace);
		if (hold != 0) begin
			in_valid <= 1'b0;
			repeat (hold) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_red   <= r;
		in_green <= g;
		in_blue  <= b;
		do @(posedge clk); while (in_ready !== 1'b1);
		predict_pixel(r, g, b);
	endtask

	// Hold the input until every queued word has come out.
	task automatic wait_for_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_boxes.size() != 0);
	endtask

	// Let pixels that close no block drain from the pipeline as well.
	task automatic settle();
		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_random_pixels(input int unsigned count, input bit saturate,
			input bit may_drain);
		int unsigned i;
		for (i = 0; i < count; i++) begin
			if (may_drain && $urandom_range(0, 199) == 0) wait_for_results();
			send_pixel(pick_channel(saturate), pick_channel(saturate), pick_channel(saturate));
		end
	endtask

	task automatic test_reset_values();
		check_registers();
		src_pace  = PACE_LIGHT;
		sink_pace = PACE_LIGHT;
		send_random_pixels(16, 1'b0, 1'b0);
		settle();
	endtask

	task automatic test_corner_blocks();
		int unsigned i;
		src_pace  = PACE_HEAVY;
		sink_pace = PACE_HEAVY;
		// full-scale block beside a block that truncates to zero
		write_image_cfg(2, 4, 2);
		for (i = 0; i < 2; i++) begin
			send_pixel(8'hFF, 8'h00, 8'hAA);
			send_pixel(8'hFF, 8'h00, 8'h55);
			send_pixel(8'h00, 8'hFF, 8'h00);
			send_pixel(8'h00, 8'hFF, PIX_W'(i + 1));
		end
		wait_for_results();
		// partial column past the last whole block
		write_image_cfg(3, 4, 3);
		for (i = 0; i < 12; i++)
			send_pixel(PIX_W'(i * 37), PIX_W'(255 - i * 19), PIX_W'(i * i));
		settle();
		// factor above both dimensions: two frames with no word at all
		write_image_cfg(4, 3, 1);
		send_random_pixels(6, 1'b0, 1'b0);
		settle();
		check_registers();
	endtask

	task automatic test_register_limits();
		src_pace  = PACE_LIGHT;
		sink_pace = PACE_HEAVY;
		// zero factor and zero size fall back to a one-pixel image
		write_image_cfg(0, 0, 0);
		check_registers();
		send_random_pixels(3, 1'b0, 1'b0);
		settle();
		// factor saturates to the largest block, summed at full scale
		src_pace = PACE_FULL;
		write_image_cfg(15, 9, 8);
		check_registers();
		send_random_pixels(72, 1'b1, 1'b0);
		settle();
		// a write past the register list leaves the frame running
		src_pace = PACE_HEAVY;
		write_image_cfg(2, 4, 2);
		send_random_pixels(3, 1'b0, 1'b0);
		settle();
		reg_write(REG_UNUSED, $urandom);
		send_random_pixels(5, 1'b0, 1'b0);
		settle();
		check_registers();
	endtask

	task automatic test_big_images();
		src_pace  = PACE_LIGHT;
		sink_pace = PACE_LIGHT;
		// width saturates to the column memory size; run the head of the first band
		write_image_cfg(2, 13'h1FFF, 2);
		check_registers();
		send_random_pixels(BIG_ITEMS, 1'b0, 1'b0);
		settle();
		// height saturates to its limit; run the first bands
		write_image_cfg(2, 2, 13'h1FFF);
		check_registers();
		send_random_pixels(BIG_ITEMS, 1'b0, 1'b0);
		settle();
		// back to a small image before the random frames
		write_image_cfg(2, 16, 8);
	endtask

	task automatic test_random_frames();
		int unsigned sent, first_word, count, frame;
		logic [PDATA_W-1:0] noise, factor, width, height;
		sent = 0;
		first_word = boxes_predicted;
		while (sent < RANDOM_ITEMS || boxes_predicted - first_word < RANDOM_WORDS) begin
			settle();
			case ($urandom_range(0, 9))
				0: factor = 1;
				1: factor = MAX_FACTOR_DEF;
				2: factor = $urandom_range(0, 15);
				default: factor = $urandom_range(1, MAX_FACTOR_DEF);
			endcase
			width  = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 40);
			height = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 16);
			noise  = ($urandom_range(0, 3) == 0) ? $urandom : 0;
			reg_write(REG_FACTOR, (noise & 32'hFFFF_FFF0) | factor);
			if ($urandom_range(0, 3) != 0) reg_write(REG_IN_WIDTH, (noise & 32'hFFFF_E000) | width);
			if ($urandom_range(0, 3) != 0) reg_write(REG_IN_HEIGHT, (noise & 32'hFFFF_E000) | height);
			check_registers();
			src_pace  = pace_t'($urandom_range(PACE_FULL, PACE_HEAVY));
			sink_pace = pace_t'($urandom_range(PACE_FULL, PACE_HEAVY));
			frame = eff_width() * eff_height();
			// mostly whole frames, sometimes two in a row, sometimes cut short
			if ($urandom_range(0, 4) == 0) count = $urandom_range(1, frame);
			else count = frame * $urandom_range(1, 2);
			send_random_pixels(count, $urandom_range(0, 5) == 0, 1'b1);
			sent += count;
		end
		settle();
	endtask

	// Compare each word taken from the output with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (expected_boxes.size() == 0) begin
				report_mismatch("word with nothing expected, red", out_red, 0);
			end else begin
				oldest = expected_boxes.pop_front();
				if (out_red !== oldest.red) report_mismatch("out_red", out_red, oldest.red);
				if (out_green !== oldest.green) report_mismatch("out_green", out_green, oldest.green);
				if (out_blue !== oldest.blue) report_mismatch("out_blue", out_blue, oldest.blue);
				if (frame_end !== oldest.frame_end)
					report_mismatch("frame_end", frame_end, oldest.frame_end);
			end
		end
	end

	initial begin : output_sink
		int unsigned hold;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			hold = draw_gap(sink_pace);
			if (hold != 0) begin
				out_ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (out_valid !== 1'b1);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready) || psel)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("box_average_downscale regression: fail");
				$finish;
			end
		end
	end

	initial begin
		restart_frame();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_values();
		test_corner_blocks();
		test_register_limits();
		test_big_images();
		test_random_frames();
		settle();
		if (mismatches == 0)
			$display("box_average_downscale regression: pass");
		else
			$display("box_average_downscale regression: fail");
		$finish;
	end

endmodule
